/* rtl/core/postfix_eval_stack_queue_heap_macros.svh */
// Assertion macros for the postfix evaluator checker.
// Included by the checker file only; depends on nothing.
`ifndef POSTFIX_EVAL_STACK_QUEUE_HEAP_MACROS_SVH
`define POSTFIX_EVAL_STACK_QUEUE_HEAP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/pfe_pkg.sv */
// Package for the postfix evaluator: token codes, status codes, beat structs.
// Depends on nothing.
`default_nettype none
package pfe_pkg;
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EOL  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] stack_result;
    logic signed [31:0] queue_result;
    logic signed [31:0] heap_result;
    logic [1:0]         line_status;
  } out_beat_t;

  // Request and reply between the sequencer and the shared ALU.
  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/pfe_alu.sv */
// Shared arithmetic unit: registered add, subtract, multiply, and signed
// division by a restoring divider one quotient bit per cycle. Uses pfe_pkg.
`default_nettype none
module pfe_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire pfe_pkg::alu_req_t req_i,
  input  wire [DATA_WIDTH-1:0]   a_i,
  input  wire [DATA_WIDTH-1:0]   b_i,
  output pfe_pkg::alu_rsp_t      rsp_o,
  output logic [DATA_WIDTH-1:0]  res_o
);
  import pfe_pkg::*;
  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  logic            busy_q, busy_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d, res_q, res_d;
  logic            neg_q, neg_d, done_q, done_d, div0_q, div0_d;
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH-1:0] ma, mb;

  always_comb begin
    ma = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
    mb = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;
    trial = {rem_q, quo_q[DATA_WIDTH-1]} - {1'b0, dvs_q};
    busy_d = busy_q; cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q;
    dvs_d = dvs_q; res_d = res_q; neg_d = neg_q; done_d = 1'b0; div0_d = 1'b0;
    if (req_i.start) begin
      case (req_i.op)
        OP_ADD: begin res_d = a_i + b_i; done_d = 1'b1; end
        OP_SUB: begin res_d = a_i - b_i; done_d = 1'b1; end
        OP_MUL: begin res_d = a_i * b_i; done_d = 1'b1; end
        default: begin
          if (b_i == '0) begin
            res_d = '0; done_d = 1'b1; div0_d = 1'b1;
          end else begin
            busy_d = 1'b1; cnt_d = CW'(DATA_WIDTH); quo_d = ma; rem_d = '0;
            dvs_d = mb; neg_d = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
          end
        end
      endcase
    end else if (busy_q) begin
      if (!trial[DATA_WIDTH]) begin
        rem_d = trial[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
        res_d = neg_q ? (~quo_d + 1'b1) : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0; div0_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d; div0_q <= div0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; res_q <= res_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.div0 = div0_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

/* rtl/core/postfix_eval_stack_queue_heap.sv */
// Top level of the postfix evaluator over a stack, a queue and a min-heap.
// Uses pfe_pkg and instantiates pfe_alu.
`default_nettype none
// Usage: drive in_i with a token and raise start_i; the token is taken at a
// rising edge where start_i is high and busy_o is low. busy_o stays high
// while the token is worked on. A number is pushed into all three stores; an
// operator pops two entries from each store, runs them one store at a time
// through the shared ALU and pushes the three results back; end of line
// pops the head of every store and presents one beat on out_o, marked by
// valid_o for exactly one cycle. That is the first cycle with busy_o low
// again. The receiver cannot stall that beat.
// How long busy_o stays high depends on the heap walks, which read one
// memory word per cycle, and, for a division, on the bit-serial divider.
// Reset clears the counts and the sticky status at once; the entry
// memories are not cleared, since only entries below the counts are read.
module postfix_eval_stack_queue_heap #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire pfe_pkg::in_beat_t in_i,
  output logic                busy_o,
  output logic                valid_o,
  output pfe_pkg::out_beat_t  out_o
);
  import pfe_pkg::*;
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  localparam logic [4:0] S_IDLE = 5'd0,  S_PUSH = 5'd1,  S_HUP_RD = 5'd2,
    S_HUP_CMP = 5'd3, S_POPS1 = 5'd4, S_POPS2 = 5'd5, S_HTOP = 5'd6,
    S_HLAST = 5'd7, S_HDN_RDL = 5'd8, S_HDN_RDR = 5'd9, S_HDN_CMP = 5'd10,
    S_HDN_SWP = 5'd11, S_ALU_S = 5'd12, S_ALU_Q = 5'd13, S_ALU_H = 5'd14,
    S_WAIT = 5'd15, S_EOL_OUT = 5'd16, S_POPQ1 = 5'd17, S_POPQ2 = 5'd18,
    S_HUP_SWP = 5'd19, S_HROOT = 5'd20;

  logic [4:0] st_q, st_d;
  logic [CW-1:0] lcnt_q, lcnt_d, fcnt_q, fcnt_d, hcnt_q, hcnt_d;
  logic [AW-1:0] fhead_q, fhead_d;
  logic [1:0] sticky_q, sticky_d;
  logic [2:0] op_q, op_d;
  logic       second_q, second_d;   // second pop of an operator
  logic [1:0] aluix_q, aluix_d;
  logic [DATA_WIDTH-1:0] v_q, v_d;          // value to push / sift
  logic [DATA_WIDTH-1:0] rs_q, rs_d, ls_q, ls_d, rq_q, rq_d, lq_q, lq_d;
  logic [DATA_WIDTH-1:0] rh_q, rh_d, lh_q, lh_d, lv_q, lv_d;
  logic [AW-1:0] hi_q, hi_d, hm_q, hm_d;
  logic [DATA_WIDTH-1:0] hm_val_q, hm_val_d;
  logic          valid_q, valid_d;
  out_beat_t     out_q, out_d;

  logic [DATA_WIDTH-1:0] lifo_mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] fifo_mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] heap_mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] lrd_q, frd_q, hrd_q;
  logic          lwe, fwe, hwe;
  logic [AW-1:0] lwa, lra, fwa, fra, hwa, hra;
  logic [DATA_WIDTH-1:0] lwd, fwd, hwd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic [DATA_WIDTH-1:0] alu_a, alu_b, alu_res;

  pfe_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk_i, .rst_ni, .req_i(alu_req), .a_i(alu_a), .b_i(alu_b),
    .rsp_o(alu_rsp), .res_o(alu_res)
  );

  always_ff @(posedge clk_i) begin
    if (lwe) lifo_mem[lwa] <= lwd;
    if (fwe) fifo_mem[fwa] <= fwd;
    if (hwe) heap_mem[hwa] <= hwd;
    lrd_q <= lifo_mem[lra];
    frd_q <= fifo_mem[fra];
    hrd_q <= heap_mem[hra];
  end

  function automatic logic lt(input logic [DATA_WIDTH-1:0] a, b);
    return $signed(a) < $signed(b);
  endfunction

  logic [AW+1:0] lchild, rchild;
  logic [DATA_WIDTH-1:0] alu_out;
  logic [CW:0]   fsum;
  logic [AW-1:0] ftail;

  // Queue tail slot, wrapped at the store depth.
  always_comb begin
    fsum  = (CW+1)'(fhead_q) + (CW+1)'(fcnt_q);
    ftail = (fsum >= (CW+1)'(STORE_DEPTH)) ? AW'(fsum - (CW+1)'(STORE_DEPTH))
                                           : AW'(fsum);
  end

  always_comb begin
    st_d = st_q; lcnt_d = lcnt_q; fcnt_d = fcnt_q; hcnt_d = hcnt_q;
    fhead_d = fhead_q; sticky_d = sticky_q; op_d = op_q; second_d = second_q;
    aluix_d = aluix_q; v_d = v_q; rs_d = rs_q; ls_d = ls_q; rq_d = rq_q;
    lq_d = lq_q; rh_d = rh_q; lh_d = lh_q; lv_d = lv_q; hi_d = hi_q;
    hm_d = hm_q; hm_val_d = hm_val_q; valid_d = 1'b0; out_d = out_q;
    lwe = 1'b0; fwe = 1'b0; hwe = 1'b0;
    lwa = '0; fwa = '0; hwa = '0; lwd = v_q; fwd = v_q; hwd = v_q;
    lra = AW'(lcnt_q - 1'b1); fra = fhead_q; hra = '0;
    alu_req = '0; alu_a = '0; alu_b = '0;
    lchild = {1'b0, hi_q, 1'b1};
    rchild = lchild + 1'b1;
    alu_out = alu_res;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = in_i.op;
          v_d  = DATA_WIDTH'($signed(in_i.operand_value));
          case (in_i.op)
            OP_PUSH: begin
              if (lcnt_q >= DEPTH_C || fcnt_q >= DEPTH_C || hcnt_q >= DEPTH_C) begin
                if (sticky_q == ST_OK) sticky_d = ST_FULL;
              end else st_d = S_PUSH;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (lcnt_q < CW'(2) || fcnt_q < CW'(2) || hcnt_q < CW'(2)) begin
                if (sticky_q == ST_OK) sticky_d = ST_EMPTY;
              end else begin
                st_d = S_POPS1; second_d = 1'b0;
              end
            end
            OP_EOL: begin
              rs_d = '0; rq_d = '0; rh_d = '0; second_d = 1'b0;
              st_d = S_POPS1;
            end
            default: st_d = S_IDLE;
          endcase
        end
      end
      // Push v_q into all three stores and start the heap sift up.
      S_PUSH: begin
        lwe = 1'b1; lwa = AW'(lcnt_q); lcnt_d = lcnt_q + 1'b1;
        fwe = 1'b1; fwa = ftail; fcnt_d = fcnt_q + 1'b1;
        hwe = 1'b1; hwa = AW'(hcnt_q); hcnt_d = hcnt_q + 1'b1;
        hi_d = AW'(hcnt_q);
        st_d = S_HUP_RD;
      end
      S_HUP_RD: begin
        if (hi_q == '0) st_d = (op_q == OP_PUSH) ? S_IDLE : S_WAIT;
        else begin
          hra = AW'((hi_q - 1'b1) >> 1);
          st_d = S_HUP_CMP;
        end
      end
      S_HUP_CMP: begin
        if (lt(v_q, hrd_q)) begin
          hwe = 1'b1; hwa = hi_q; hwd = hrd_q;
          hi_d = AW'((hi_q - 1'b1) >> 1);
          st_d = S_HUP_SWP;
        end else st_d = (op_q == OP_PUSH) ? S_IDLE : S_WAIT;
      end
      S_HUP_SWP: begin
        hwe = 1'b1; hwa = hi_q; hwd = v_q;
        st_d = S_HUP_RD;
      end
      // LIFO pops: the read at lcnt-1 is issued in S_POPS1 and used in S_POPS2.
      S_POPS1: begin
        if (op_q == OP_EOL) begin
          if (lcnt_q != '0) begin
            lcnt_d = lcnt_q - 1'b1;
            st_d = S_POPS2;
          end else begin
            if (sticky_q == ST_OK) sticky_d = ST_EMPTY;
            st_d = S_POPQ1;
          end
        end else begin
          lcnt_d = lcnt_q - 1'b1;
          st_d = S_POPS2;
        end
      end
      S_POPS2: begin
        if (op_q == OP_EOL) begin
          rs_d = lrd_q; st_d = S_POPQ1;
        end else if (!second_q) begin
          rs_d = lrd_q; second_d = 1'b1; st_d = S_POPS1;
        end else begin
          ls_d = lrd_q; second_d = 1'b0; st_d = S_POPQ1;
        end
      end
      S_POPQ1: begin
        if (op_q == OP_EOL && fcnt_q == '0) begin
          if (sticky_d == ST_OK) sticky_d = ST_EMPTY;
          st_d = S_HTOP;
        end else begin
          fhead_d = (fhead_q == AW'(STORE_DEPTH - 1)) ? '0 : fhead_q + 1'b1;
          fcnt_d = fcnt_q - 1'b1;
          st_d = S_POPQ2;
        end
      end
      S_POPQ2: begin
        if (op_q == OP_EOL) begin
          rq_d = frd_q; st_d = S_HTOP;
        end else if (!second_q) begin
          rq_d = frd_q; second_d = 1'b1; st_d = S_POPQ1;
        end else begin
          lq_d = frd_q; second_d = 1'b0; st_d = S_HTOP;
        end
        hra = '0;
      end
      // Heap pop: S_HTOP sees the root (read issued at address zero).
      S_HTOP: begin
        if (op_q == OP_EOL && hcnt_q == '0) begin
          if (sticky_q == ST_OK) sticky_d = ST_EMPTY;
          st_d = S_EOL_OUT;
        end else begin
          if (second_q) lh_d = hrd_q; else rh_d = hrd_q;
          hcnt_d = hcnt_q - 1'b1;
          hra = AW'(hcnt_q - 1'b1);
          st_d = S_HLAST;
        end
      end
      S_HLAST: begin
        lv_d = hrd_q; hi_d = '0;
        hwe = 1'b1; hwa = '0; hwd = hrd_q;
        st_d = S_HDN_RDL;
      end
      S_HDN_RDL: begin
        hm_d = hi_q; hm_val_d = lv_q;
        if (lchild < (AW+2)'(hcnt_q)) begin
          hra = AW'(lchild); st_d = S_HDN_RDR;
        end else st_d = S_HDN_SWP;
      end
      S_HDN_RDR: begin
        if (lt(hrd_q, hm_val_q)) begin
          hm_d = AW'(lchild); hm_val_d = hrd_q;
        end
        if (rchild < (AW+2)'(hcnt_q)) begin
          hra = AW'(rchild); st_d = S_HDN_CMP;
        end else st_d = S_HDN_SWP;
      end
      S_HDN_CMP: begin
        if (lt(hrd_q, hm_val_q)) begin
          hm_d = AW'(rchild); hm_val_d = hrd_q;
        end
        st_d = S_HDN_SWP;
      end
      // The smaller child moves up into the hole; the moving value is kept
      // in lv_q and written once, where it comes to rest.
      S_HDN_SWP: begin
        if (hm_q == hi_q) begin
          hwe = 1'b1; hwa = hi_q; hwd = lv_q;
          if (op_q == OP_EOL) st_d = S_EOL_OUT;
          else if (!second_q) begin
            second_d = 1'b1; st_d = S_HROOT;
          end else begin
            aluix_d = 2'd0; st_d = S_ALU_S;
          end
        end else begin
          hwe = 1'b1; hwa = hi_q; hwd = hm_val_q;
          hi_d = hm_q;
          st_d = S_HDN_RDL;
        end
      end
      // Root read for the second pop, after the last sift write has landed.
      S_HROOT: begin
        hra = '0;
        st_d = S_HTOP;
      end
      S_ALU_S: begin
        alu_req.start = 1'b1; alu_req.op = op_q;
        case (aluix_q)
          2'd0: begin alu_a = ls_q; alu_b = rs_q; end
          2'd1: begin alu_a = lq_q; alu_b = rq_q; end
          default: begin alu_a = lh_q; alu_b = rh_q; end
        endcase
        st_d = S_ALU_Q;
      end
      S_ALU_Q: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div0 && sticky_q == ST_OK) sticky_d = ST_DIV0;
          case (aluix_q)
            2'd0: begin rs_d = alu_out; aluix_d = 2'd1; st_d = S_ALU_S; end
            2'd1: begin rq_d = alu_out; aluix_d = 2'd2; st_d = S_ALU_S; end
            default: begin rh_d = alu_out; st_d = S_ALU_H; end
          endcase
        end
      end
      S_ALU_H: begin
        lwe = 1'b1; lwa = AW'(lcnt_q); lwd = rs_q; lcnt_d = lcnt_q + 1'b1;
        fwe = 1'b1; fwa = ftail; fwd = rq_q;
        fcnt_d = fcnt_q + 1'b1;
        hwe = 1'b1; hwa = AW'(hcnt_q); hwd = rh_q; hcnt_d = hcnt_q + 1'b1;
        hi_d = AW'(hcnt_q); v_d = rh_q;
        st_d = S_HUP_RD;
      end
      S_WAIT: st_d = S_IDLE;
      S_EOL_OUT: begin
        valid_d = 1'b1;
        out_d.stack_result = 32'($signed(rs_q));
        out_d.queue_result = 32'($signed(rq_q));
        out_d.heap_result  = 32'($signed(rh_q));
        out_d.line_status  = sticky_q;
        sticky_d = ST_OK;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; lcnt_q <= '0; fcnt_q <= '0; hcnt_q <= '0;
      fhead_q <= '0; sticky_q <= ST_OK; valid_q <= 1'b0;
      second_q <= 1'b0; aluix_q <= '0;
    end else begin
      st_q <= st_d; lcnt_q <= lcnt_d; fcnt_q <= fcnt_d; hcnt_q <= hcnt_d;
      fhead_q <= fhead_d; sticky_q <= sticky_d; valid_q <= valid_d;
      second_q <= second_d; aluix_q <= aluix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; v_q <= v_d; rs_q <= rs_d; ls_q <= ls_d; rq_q <= rq_d;
    lq_q <= lq_d; rh_q <= rh_d; lh_q <= lh_d; hi_q <= hi_d;
    hm_q <= hm_d; hm_val_q <= hm_val_d; out_q <= out_d;
    lv_q <= lv_d;
  end

  assign busy_o  = (st_q != S_IDLE);
  assign valid_o = valid_q;
  assign out_o   = out_q;
endmodule
`default_nettype wire

/* rtl/core/pfe_checker.sv */
// Port-level checker for the postfix evaluator, bound to the top level.
// Uses pfe_pkg and the assertion macros header.
`default_nettype none
`include "postfix_eval_stack_queue_heap_macros.svh"
module pfe_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                start_i,
  input wire pfe_pkg::in_beat_t  in_i,
  input wire                busy_o,
  input wire                valid_o,
  input wire pfe_pkg::out_beat_t out_o
);
  import pfe_pkg::*;
  // A result beat follows only from an end-of-line token, so busy was high.
  `PF_ASSERT_IMP(a_valid_busy, clk_i, rst_ni, valid_o, $past(busy_o), "result without work")
  // A result beat lasts exactly one cycle.
  `PF_ASSERT_NXT(a_valid_pulse, clk_i, rst_ni, valid_o, !valid_o, "result held twice")
  // Accepting an end-of-line token makes the block busy.
  `PF_ASSERT_NXT(a_eol_busy, clk_i, rst_ni, start_i && !busy_o && in_i.op == OP_EOL,
    busy_o, "end of line not taken")
  // Any accepted token never yields a result in the next cycle.
  `PF_ASSERT_NXT(a_no_fast, clk_i, rst_ni, start_i && !busy_o, !valid_o, "result too early")
endmodule
bind postfix_eval_stack_queue_heap pfe_checker u_pfe_checker (
  .clk_i, .rst_ni, .start_i, .in_i, .busy_o, .valid_o, .out_o
);
`default_nettype wire
